[rtl/tsa_pkg.sv]
// Shared types, codes and sizes for the tagged slot allocator.
package tsa_pkg;

   localparam int SLOTS_DEFAULT   = 32;
   localparam int MAX_ADDRESSABLE = 32;

   localparam logic CMD_ALLOCATE = 1'b0;
   localparam logic CMD_FREE     = 1'b1;

   localparam logic [2:0] STATUS_MATCHED      = 3'd0;
   localparam logic [2:0] STATUS_CLAIMED      = 3'd1;
   localparam logic [2:0] STATUS_NO_FREE      = 3'd2;
   localparam logic [2:0] STATUS_FREED        = 3'd3;
   localparam logic [2:0] STATUS_FREED_UNUSED = 3'd4;

   localparam logic signed [5:0] NO_SLOT = -6'sd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_PICK,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic               command;
      logic [31:0]        texture_tag;
      logic [31:0]        special_flags;
      logic [3:0]         mip_level;
      logic [5:0]         window_low;
      logic [5:0]         window_high;
      logic signed [5:0]  hint_slot;
      logic [4:0]         slot_to_free;
   } req_item_type;

   typedef struct packed {
      logic signed [5:0]  slot;
      logic [2:0]         status;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic compare;
      logic pick;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic incoming_free;
   } dp_status_type;

endpackage

[rtl/tsa_req_if.sv]
// Request channel interface of the tagged slot allocator.
interface tsa_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic [31:0]        texture_tag;
   logic [31:0]        special_flags;
   logic [3:0]         mip_level;
   logic [5:0]         window_low;
   logic [5:0]         window_high;
   logic signed [5:0]  hint_slot;
   logic [4:0]         slot_to_free;

   modport source (
      output valid, command, texture_tag, special_flags, mip_level,
             window_low, window_high, hint_slot, slot_to_free,
      input  ready
   );

   modport sink (
      input  valid, command, texture_tag, special_flags, mip_level,
             window_low, window_high, hint_slot, slot_to_free,
      output ready
   );
endinterface

[rtl/tsa_rsp_if.sv]
// Response channel interface of the tagged slot allocator.
interface tsa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [5:0]  slot;
   logic [2:0]         status;

   modport source (
      output valid, slot, status,
      input  ready
   );

   modport sink (
      input  valid, slot, status,
      output ready
   );
endinterface

[rtl/tsa_datapath.sv]
// Slot table, parallel key compare, priority pick and commit logic.
module tsa_datapath #(
   parameter int SLOTS = tsa_pkg::SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tsa_pkg::ctrl_cmd_type cmd,
   output tsa_pkg::dp_status_type status,
   input  tsa_pkg::req_item_type req_item,
   output tsa_pkg::rsp_item_type rsp_item
);

   localparam int ADDR   = (SLOTS < tsa_pkg::MAX_ADDRESSABLE) ? SLOTS
                                                             : tsa_pkg::MAX_ADDRESSABLE;
   localparam int ADDR_W = $clog2(ADDR);

   // Slot table.
   logic [ADDR-1:0]  in_use_ff;
   logic [ADDR-1:0]  in_use_in;
   logic [31:0]      texture_ff [ADDR];
   logic [31:0]      flags_ff   [ADDR];
   logic [3:0]       level_ff   [ADDR];
   logic [31:0]      last_use_ff[ADDR];
   logic [31:0]      use_counter_ff;
   logic [31:0]      use_counter_in;

   // Request, compare and pick registers.
   tsa_pkg::req_item_type req_ff;
   logic [ADDR-1:0]  match_ff;
   logic [ADDR-1:0]  match_in;
   logic [ADDR-1:0]  free_ff;
   logic [ADDR-1:0]  free_in;
   logic             hint_hit_ff;
   logic             hint_hit_in;
   logic [ADDR_W-1:0] pick_idx_ff;
   logic [ADDR_W-1:0] pick_idx_in;
   logic [2:0]       pick_status_ff;
   logic [2:0]       pick_status_in;
   tsa_pkg::rsp_item_type rsp_ff;
   tsa_pkg::rsp_item_type rsp_in;

   logic [5:0]       hi_clamp;
   logic [ADDR-1:0]  hint_sel;
   logic [ADDR_W-1:0] last_match_idx;
   logic [ADDR_W-1:0] first_free_idx;
   logic [ADDR_W-1:0] victim_idx;
   logic             victim_ok;
   logic             key_we;
   logic             level_we;
   logic             stamp_we;
   logic [3:0]       level_new;

   assign status.incoming_free = (req_item.command == tsa_pkg::CMD_FREE);
   assign rsp_item = rsp_ff;

   // Compare stage: every slot checks the window and the key at once.
   always_comb begin
      hi_clamp = (req_ff.window_high > 6'(ADDR)) ? 6'(ADDR) : req_ff.window_high;
      for (int i = 0; i < ADDR; i++) begin
         match_in[i] = (6'(i) >= req_ff.window_low) && (6'(i) < hi_clamp) && in_use_ff[i]
                       && (texture_ff[i] == req_ff.texture_tag)
                       && (flags_ff[i] == req_ff.special_flags);
         free_in[i]  = (6'(i) >= req_ff.window_low) && (6'(i) < hi_clamp) && !in_use_ff[i];
         hint_sel[i] = !req_ff.hint_slot[5] && (req_ff.hint_slot[4:0] == 5'(i));
      end
      hint_hit_in = |(match_in & hint_sel);
   end

   // Pick stage: the hint wins, then the highest match, then the lowest free slot.
   always_comb begin
      last_match_idx = '0;
      first_free_idx = '0;
      for (int i = 0; i < ADDR; i++) begin
         if (match_ff[i]) begin
            last_match_idx = ADDR_W'(i);
         end
      end
      for (int i = ADDR - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            first_free_idx = ADDR_W'(i);
         end
      end
      if (hint_hit_ff) begin
         pick_idx_in    = req_ff.hint_slot[ADDR_W-1:0];
         pick_status_in = tsa_pkg::STATUS_MATCHED;
      end else if (|match_ff) begin
         pick_idx_in    = last_match_idx;
         pick_status_in = tsa_pkg::STATUS_MATCHED;
      end else if (|free_ff) begin
         pick_idx_in    = first_free_idx;
         pick_status_in = tsa_pkg::STATUS_CLAIMED;
      end else begin
         pick_idx_in    = '0;
         pick_status_in = tsa_pkg::STATUS_NO_FREE;
      end
   end

   // Commit stage: table updates and the result.
   always_comb begin
      victim_idx     = req_ff.slot_to_free[ADDR_W-1:0];
      victim_ok      = (6'(req_ff.slot_to_free) < 6'(ADDR)) && in_use_ff[victim_idx];
      in_use_in      = in_use_ff;
      use_counter_in = use_counter_ff;
      key_we         = 1'b0;
      level_we       = 1'b0;
      stamp_we       = 1'b0;
      level_new      = req_ff.mip_level;
      rsp_in         = rsp_ff;
      if (cmd.commit) begin
         if (req_ff.command == tsa_pkg::CMD_FREE) begin
            rsp_in.slot = $signed({1'b0, req_ff.slot_to_free});
            if (victim_ok) begin
               in_use_in[victim_idx] = 1'b0;
               rsp_in.status = tsa_pkg::STATUS_FREED;
            end else begin
               rsp_in.status = tsa_pkg::STATUS_FREED_UNUSED;
            end
         end else begin
            use_counter_in = use_counter_ff + 32'd1;
            rsp_in.status  = pick_status_ff;
            rsp_in.slot    = $signed(6'(pick_idx_ff));
            case (pick_status_ff)
               tsa_pkg::STATUS_MATCHED: begin
                  stamp_we = 1'b1;
                  if (req_ff.mip_level < level_ff[pick_idx_ff]) begin
                     level_we = 1'b1;
                  end
               end
               tsa_pkg::STATUS_CLAIMED: begin
                  key_we   = 1'b1;
                  level_we = 1'b1;
                  stamp_we = 1'b1;
                  in_use_in[pick_idx_ff] = 1'b1;
               end
               default: begin
                  rsp_in.slot = tsa_pkg::NO_SLOT;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff      <= '0;
         use_counter_ff <= '0;
      end else begin
         in_use_ff      <= in_use_in;
         use_counter_ff <= use_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         texture_ff[pick_idx_ff] <= req_ff.texture_tag;
         flags_ff[pick_idx_ff]   <= req_ff.special_flags;
      end
      if (level_we) begin
         level_ff[pick_idx_ff] <= level_new;
      end
      if (stamp_we) begin
         last_use_ff[pick_idx_ff] <= use_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (cmd.compare) begin
         match_ff    <= match_in;
         free_ff     <= free_in;
         hint_hit_ff <= hint_hit_in;
      end
      if (cmd.pick) begin
         pick_idx_ff    <= pick_idx_in;
         pick_status_ff <= pick_status_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

[rtl/tsa_control.sv]
// Sequencing state machine and response valid flag of the allocator.
module tsa_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  tsa_pkg::dp_status_type status,
   output tsa_pkg::ctrl_cmd_type  cmd
);

   tsa_pkg::state_type state_ff;
   tsa_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         tsa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.incoming_free ? tsa_pkg::ST_COMMIT : tsa_pkg::ST_MATCH;
            end
         end
         tsa_pkg::ST_MATCH: begin
            cmd.compare = 1'b1;
            state_in    = tsa_pkg::ST_PICK;
         end
         tsa_pkg::ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = tsa_pkg::ST_COMMIT;
         end
         tsa_pkg::ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = tsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsa_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);
   end

   // An accepted request always starts a compare or, for a free, goes to commit.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=>
         (state_ff == tsa_pkg::ST_MATCH || state_ff == tsa_pkg::ST_COMMIT))
      else $error("accepted request did not start processing");

   // A response only appears out of the commit step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == tsa_pkg::ST_COMMIT))
      else $error("response valid rose outside commit");

   // A stalled response holds the finished item in commit.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsa_pkg::ST_COMMIT && rsp_valid_ff && !rsp_ready) |=>
         (state_ff == tsa_pkg::ST_COMMIT))
      else $error("commit left while the response register was full");

endmodule

[rtl/tagged_slot_allocator.sv]
// Top level of the tagged slot allocator: channels, controller and datapath.
//
// The allocator keeps a fully associative table of up to 32 slots, each holding a texture
// tag, a special-flags word, a level and a use stamp. An allocate request searches the slot
// window [window_low, window_high), clamped to the table: a hint slot that is in the
// window, in use and matching the key is taken first, otherwise the highest matching slot,
// and a match lowers the stored level to the smaller of the two. Without a match the lowest
// free slot in the window is claimed and filled, and with none free the request fails with
// slot -1. Every allocate advances a wrapping use counter that stamps the granted slot. A
// free request releases one slot and reports a slot that was not in use. Requests are
// handled one at a time by a four-state sequencer: an allocate passes through accept,
// parallel key compare over all slots, priority pick and commit, and a free through
// accept and commit; commit loads the response register. The next request is accepted
// while a finished response still waits in the output register; commit of the following
// item stalls until that response transfers. After reset the table is empty and
// requests are taken at once.
module tagged_slot_allocator #(
   parameter int SLOTS = tsa_pkg::SLOTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   tsa_req_if.sink   req_if,
   tsa_rsp_if.source rsp_if
);

   tsa_pkg::ctrl_cmd_type  cmd;
   tsa_pkg::dp_status_type status;
   tsa_pkg::req_item_type  req_item;
   tsa_pkg::rsp_item_type  rsp_item;

   // Gather the request fields into one item for the datapath.
   always_comb begin
      req_item.command       = req_if.command;
      req_item.texture_tag   = req_if.texture_tag;
      req_item.special_flags = req_if.special_flags;
      req_item.mip_level     = req_if.mip_level;
      req_item.window_low    = req_if.window_low;
      req_item.window_high   = req_if.window_high;
      req_item.hint_slot     = req_if.hint_slot;
      req_item.slot_to_free  = req_if.slot_to_free;
   end

   // The response fields come straight from the datapath's output register.
   assign rsp_if.slot   = rsp_item.slot;
   assign rsp_if.status = rsp_item.status;

   tsa_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tsa_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule
